/* rtl/jacf_pkg.sv */
// shared constants, joint limit tables, fsm state type and command struct
// for the joint angle command framer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jacf_pkg;

  localparam int JOINT_COUNT = 24;
  localparam int TABLE_SIZE  = 24;
  localparam int HDR_LEN     = 3;
  localparam int FRAME_LEN   = JOINT_COUNT + 5;
  localparam int POS_W       = $clog2(FRAME_LEN);
  localparam int JOINT_IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  localparam int IDX_IN_W  = 5;
  localparam int ANGLE_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int DIFF_W    = 15;
  localparam int SPAN_W    = 15;
  localparam int PROD_W    = DIFF_W + BYTE_W;
  localparam int DIV_STEPS = 8;
  localparam int DVS_W     = SPAN_W + DIV_STEPS - 1;

  localparam logic [BYTE_W-1:0] FRAME_START = 8'hFE;
  localparam logic [BYTE_W-1:0] FRAME_SET   = 8'h74;
  localparam logic [BYTE_W-1:0] FRAME_COUNT = 8'h18;
  localparam logic [BYTE_W-1:0] FRAME_STOP  = 8'h01;
  localparam logic [BYTE_W-1:0] SUM_SEED    = 8'd24;

  // clamp bounds with margin folded in, q4.12 radians
  localparam logic signed [ANGLE_W:0] JOINT_HI_LIM [TABLE_SIZE] = '{
    17'sd18226, 17'sd18226, 17'sd18226, 17'sd18226,
    17'sd18226, 17'sd18226, 17'sd18226, 17'sd18226,
    17'sd8415, 17'sd3982, 17'sd3213, 17'sd9598, 17'sd6430, 17'sd1843, 17'sd2028,
    17'sd8575, 17'sd4142, 17'sd3213, 17'sd9803, 17'sd6430, 17'sd1843, 17'sd2028,
    17'sd18226, 17'sd18226
  };

  localparam logic signed [ANGLE_W:0] JOINT_LO_LIM [TABLE_SIZE] = '{
    17'sd4, 17'sd4, 17'sd4, 17'sd4, 17'sd4, 17'sd4, 17'sd4, 17'sd4,
    -17'sd1123, -17'sd908, -17'sd3213, 17'sd1840, -17'sd4643, -17'sd1101, -17'sd2847,
    -17'sd1283, -17'sd1068, -17'sd3213, 17'sd1635, -17'sd4643, -17'sd1101, -17'sd2847,
    17'sd4, 17'sd4
  };

  localparam logic signed [ANGLE_W:0] JOINT_LO [TABLE_SIZE] = '{
    17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0,
    -17'sd1287, -17'sd1072, -17'sd3217, 17'sd1430, -17'sd4647, -17'sd1105, -17'sd2851,
    -17'sd1287, -17'sd1072, -17'sd3217, 17'sd1430, -17'sd4647, -17'sd1105, -17'sd2851,
    17'sd0, 17'sd0
  };

  // full joint range, hi - lo
  localparam logic [SPAN_W-1:0] JOINT_SPAN [TABLE_SIZE] = '{
    15'd18230, 15'd18230, 15'd18230, 15'd18230,
    15'd18230, 15'd18230, 15'd18230, 15'd18230,
    15'd9866, 15'd5218, 15'd6434, 15'd8578, 15'd11081, 15'd2952, 15'd4883,
    15'd9866, 15'd5218, 15'd6434, 15'd8578, 15'd11081, 15'd2952, 15'd4883,
    15'd18230, 15'd18230
  };

  // default angles already clamped and scaled
  localparam logic [BYTE_W-1:0] STORE_DEFAULT [TABLE_SIZE] = '{
    8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd128, 8'd128, 8'd128,
    8'd33, 8'd52, 8'd127, 8'd148, 8'd106, 8'd95, 8'd148,
    8'd33, 8'd52, 8'd127, 8'd148, 8'd106, 8'd95, 8'd148,
    8'd0, 8'd128
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL,
    ST_DIV,
    ST_WRITE,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic             load;
    logic             clamp;
    logic             mul;
    logic             div_step;
    logic             store_wr;
    logic             emit;
    logic [POS_W-1:0] pos;
  } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/jacf_ctrl.sv */
// controller fsm: sequences the scale steps of a set item and the bytes of a frame
// depends on jacf_pkg
`timescale 1ns / 1ps
`default_nettype none

module jacf_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          req_type_i,
  input  wire logic [jacf_pkg::IDX_IN_W-1:0] joint_index_i,
  output logic                               busy_o,
  output jacf_pkg::dp_cmd_t                  cmd_o
);

  jacf_pkg::state_e                state_q, state_d;
  logic [jacf_pkg::POS_W-1:0]      cnt_q, cnt_d;
  logic                            accept;
  logic                            idx_ok;
  logic                            div_last;
  logic                            send_last;

  assign accept    = start_i && (state_q == jacf_pkg::ST_IDLE);
  assign idx_ok    = joint_index_i < jacf_pkg::IDX_IN_W'(jacf_pkg::JOINT_COUNT);
  assign div_last  = cnt_q == jacf_pkg::POS_W'(jacf_pkg::DIV_STEPS - 1);
  assign send_last = cnt_q == jacf_pkg::POS_W'(jacf_pkg::FRAME_LEN - 1);

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    case (state_q)
      jacf_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type_i) begin
            state_d = jacf_pkg::ST_SEND;
          end else if (idx_ok) begin
            state_d = jacf_pkg::ST_CLAMP;
          end
        end
      end
      jacf_pkg::ST_CLAMP: state_d = jacf_pkg::ST_MUL;
      jacf_pkg::ST_MUL:   state_d = jacf_pkg::ST_DIV;
      jacf_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = jacf_pkg::ST_WRITE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      jacf_pkg::ST_WRITE: state_d = jacf_pkg::ST_IDLE;
      jacf_pkg::ST_SEND: begin
        if (send_last) begin
          state_d = jacf_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = jacf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.pos      = cnt_q;
    busy_o         = 1'b1;
    case (state_q)
      jacf_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = accept;
      end
      jacf_pkg::ST_CLAMP: cmd_o.clamp    = 1'b1;
      jacf_pkg::ST_MUL:   cmd_o.mul      = 1'b1;
      jacf_pkg::ST_DIV:   cmd_o.div_step = 1'b1;
      jacf_pkg::ST_WRITE: cmd_o.store_wr = 1'b1;
      jacf_pkg::ST_SEND:  cmd_o.emit     = 1'b1;
      default:            busy_o         = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jacf_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/jacf_datapath.sv */
// datapath: angle clamp, scale by 255 over an 8-step restoring divider,
// target store, checksum and registered frame output; depends on jacf_pkg
`timescale 1ns / 1ps
`default_nettype none

module jacf_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire jacf_pkg::dp_cmd_t             cmd_i,
  input  wire logic [jacf_pkg::IDX_IN_W-1:0] joint_index_i,
  input  wire logic signed [jacf_pkg::ANGLE_W-1:0] angle_i,
  output logic                               byte_valid_o,
  output logic [jacf_pkg::BYTE_W-1:0]        frame_byte_o,
  output logic                               last_byte_o
);

  logic [jacf_pkg::IDX_IN_W-1:0]       idx_q;
  logic signed [jacf_pkg::ANGLE_W-1:0] angle_q;
  logic [jacf_pkg::DIFF_W-1:0]         diff_q, diff_d;
  logic [jacf_pkg::PROD_W-1:0]         rem_q, rem_d;
  logic [jacf_pkg::DVS_W-1:0]          dvs_q, dvs_d;
  logic [jacf_pkg::BYTE_W-1:0]         quot_q, quot_d;
  logic [jacf_pkg::BYTE_W-1:0]         store_q [jacf_pkg::JOINT_COUNT];
  logic [jacf_pkg::BYTE_W-1:0]         sum_q, sum_d;
  logic                                valid_q;
  logic [jacf_pkg::BYTE_W-1:0]         byte_q, byte_d;
  logic                                last_q, last_d;

  logic [jacf_pkg::IDX_IN_W-1:0]       tidx;
  logic signed [jacf_pkg::ANGLE_W:0]   a_ext, a_cl, dif;
  logic [jacf_pkg::PROD_W-1:0]         prod;
  logic                                ge;
  logic [jacf_pkg::POS_W-1:0]          rd_off;
  logic [jacf_pkg::BYTE_W-1:0]         rd_byte;
  logic                                in_store;

  // guard table reads against indexes that never reach the scaler
  assign tidx = (idx_q < jacf_pkg::IDX_IN_W'(jacf_pkg::TABLE_SIZE)) ? idx_q : '0;

  always_comb begin
    a_ext = {angle_q[jacf_pkg::ANGLE_W-1], angle_q};
    if (a_ext >= jacf_pkg::JOINT_HI_LIM[tidx]) begin
      a_cl = jacf_pkg::JOINT_HI_LIM[tidx];
    end else if (a_ext <= jacf_pkg::JOINT_LO_LIM[tidx]) begin
      a_cl = jacf_pkg::JOINT_LO_LIM[tidx];
    end else begin
      a_cl = a_ext;
    end
    dif    = a_cl - jacf_pkg::JOINT_LO[tidx];
    diff_d = (dif > 0) ? dif[jacf_pkg::DIFF_W-1:0] : '0;
  end

  // x * 255 as (x << 8) - x
  assign prod = {diff_q, {jacf_pkg::BYTE_W{1'b0}}}
              - {{jacf_pkg::BYTE_W{1'b0}}, diff_q};

  assign ge = rem_q >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (cmd_i.mul) begin
      rem_d  = prod;
      dvs_d  = {jacf_pkg::JOINT_SPAN[tidx], {(jacf_pkg::DIV_STEPS - 1){1'b0}}};
      quot_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d  = ge ? (rem_q - {1'b0, dvs_q}) : rem_q;
      dvs_d  = dvs_q >> 1;
      quot_d = {quot_q[jacf_pkg::BYTE_W-2:0], ge};
    end
  end

  // frame byte select
  assign rd_off   = cmd_i.pos - jacf_pkg::POS_W'(jacf_pkg::HDR_LEN);
  assign in_store = (cmd_i.pos >= jacf_pkg::POS_W'(jacf_pkg::HDR_LEN))
                 && (cmd_i.pos < jacf_pkg::POS_W'(jacf_pkg::HDR_LEN + jacf_pkg::JOINT_COUNT));
  assign rd_byte  = in_store ? store_q[rd_off[jacf_pkg::JOINT_IDX_W-1:0]] : '0;

  always_comb begin
    sum_d  = sum_q;
    last_d = 1'b0;
    if (cmd_i.pos == jacf_pkg::POS_W'(0)) begin
      byte_d = jacf_pkg::FRAME_START;
    end else if (cmd_i.pos == jacf_pkg::POS_W'(1)) begin
      byte_d = jacf_pkg::FRAME_SET;
    end else if (cmd_i.pos == jacf_pkg::POS_W'(2)) begin
      byte_d = jacf_pkg::FRAME_COUNT;
    end else if (in_store) begin
      byte_d = rd_byte;
      sum_d  = sum_q + rd_byte;
    end else if (cmd_i.pos == jacf_pkg::POS_W'(jacf_pkg::HDR_LEN + jacf_pkg::JOINT_COUNT)) begin
      byte_d = jacf_pkg::BYTE_W'(0) - sum_q;
    end else begin
      byte_d = jacf_pkg::FRAME_STOP;
      last_d = 1'b1;
      sum_d  = jacf_pkg::SUM_SEED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q   <= joint_index_i;
      angle_q <= angle_i;
    end
    if (cmd_i.clamp) begin
      diff_q <= diff_d;
    end
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
    if (cmd_i.emit) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < jacf_pkg::JOINT_COUNT; j++) begin
        store_q[j] <= jacf_pkg::STORE_DEFAULT[j];
      end
      sum_q   <= jacf_pkg::SUM_SEED;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.store_wr) begin
        store_q[idx_q[jacf_pkg::JOINT_IDX_W-1:0]] <= quot_q;
      end
      if (cmd_i.emit) begin
        sum_q <= sum_d;
      end
      valid_q <= cmd_i.emit;
    end
  end

  assign byte_valid_o = valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;

endmodule

`default_nettype wire

/* rtl/joint_angle_command_framer.sv */
// top level of the joint angle command framer: controller plus datapath
// depends on jacf_pkg, jacf_ctrl, jacf_datapath
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  request  | start_i, busy_o            | req_type_i, joint_index_i, angle_i
//  frame    | byte_valid_o (one cycle)   | frame_byte_o, last_byte_o
//
// a request beat is taken on a rising edge with start_i high and busy_o low.
// a set beat with a valid joint runs clamp, x255 product, 8 steps of the
// shared restoring divider and store write; a set beat for a joint out of
// range is dropped. a send beat gives one frame byte per cycle from the store
// walk, the first once the send state is entered and its byte registered, the
// stop byte in the cycle busy_o drops. reset restores the default targets at
// once. the receiver cannot stall: every byte is valid for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module joint_angle_command_framer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          req_type_i,
  input  wire logic [jacf_pkg::IDX_IN_W-1:0] joint_index_i,
  input  wire logic signed [jacf_pkg::ANGLE_W-1:0] angle_i,
  output logic                               byte_valid_o,
  output logic [jacf_pkg::BYTE_W-1:0]        frame_byte_o,
  output logic                               last_byte_o
);

  jacf_pkg::dp_cmd_t cmd;

  jacf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .req_type_i    (req_type_i),
    .joint_index_i (joint_index_i),
    .busy_o        (busy_o),
    .cmd_o         (cmd)
  );

  jacf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .joint_index_i (joint_index_i),
    .angle_i       (angle_i),
    .byte_valid_o  (byte_valid_o),
    .frame_byte_o  (frame_byte_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

`default_nettype wire

/* rtl/jacf_checker.sv */
// port-level checks for the joint angle command framer, bound to the top level
// depends on jacf_pkg and joint_angle_command_framer
`timescale 1ns / 1ps
`default_nettype none

module jacf_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic                          req_type_i,
  input wire logic                          byte_valid_o,
  input wire logic [jacf_pkg::BYTE_W-1:0]   frame_byte_o,
  input wire logic                          last_byte_o
);

  // a send beat opens its frame with a valid start byte
  a_frame_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_type_i |-> ##2 byte_valid_o
      && (frame_byte_o == jacf_pkg::FRAME_START))
    else $error("send beat did not open a frame");

  // bytes before the stop byte come while busy
  a_body_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_o && !last_byte_o |-> busy_o)
    else $error("frame byte outside busy window");

  // the stop byte follows a contiguous byte run
  a_stop_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_o && last_byte_o |-> $past(byte_valid_o)
      && (frame_byte_o == jacf_pkg::FRAME_STOP))
    else $error("bad stop byte");

  // a gap always follows the end of a frame
  a_gap_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_o && last_byte_o |=> !byte_valid_o)
    else $error("no gap after frame end");

endmodule

bind joint_angle_command_framer jacf_checker u_jacf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .req_type_i   (req_type_i),
  .byte_valid_o (byte_valid_o),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);

`default_nettype wire

/* test/testbench.sv */
// self-checking bench for joint_angle_command_framer: tracks the joint target bytes,
// predicts every command frame and checks each frame byte as it leaves the block
// depends on jacf_pkg and joint_angle_command_framer
`timescale 1ns / 1ps

module testbench;

  typedef enum logic {
    REQ_SET  = 1'b0,
    REQ_SEND = 1'b1
  } req_e;

  typedef struct {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  // joint limits, margins and reset angles, q4.12 radians
  localparam int JNT_HI [24] = '{
    18230, 18230, 18230, 18230, 18230, 18230, 18230, 18230,
    8579, 4146, 3217, 10008, 6434, 1847, 2032,
    8579, 4146, 3217, 10008, 6434, 1847, 2032,
    18230, 18230
  };
  localparam int JNT_LO [24] = '{
    0, 0, 0, 0, 0, 0, 0, 0,
    -1287, -1072, -3217, 1430, -4647, -1105, -2851,
    -1287, -1072, -3217, 1430, -4647, -1105, -2851,
    0, 0
  };
  localparam int JNT_MARGIN [24] = '{
    4, 4, 4, 4, 4, 4, 4, 4,
    164, 164, 4, 410, 4, 4, 4,
    4, 4, 4, 205, 4, 4, 4,
    4, 4
  };
  localparam int JNT_DEFAULT [24] = '{
    9151, 9151, 9151, 9151, 0, 9151, 9151, 9151,
    0, 0, 0, 6434, 0, 0, 0,
    0, 0, 0, 6434, 0, 0, 0,
    0, 9151
  };

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start_i;
  logic                                busy_o;
  logic                                req_type_i;
  logic [jacf_pkg::IDX_IN_W-1:0]       joint_index_i;
  logic signed [jacf_pkg::ANGLE_W-1:0] angle_i;
  logic                                byte_valid_o;
  logic [jacf_pkg::BYTE_W-1:0]         frame_byte_o;
  logic                                last_byte_o;

  logic [7:0]  joint_target [24];
  frame_beat_t frame_due [$];
  int          mismatch_cnt;
  bit          idle_on;

  joint_angle_command_framer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .joint_index_i (joint_index_i),
    .angle_i       (angle_i),
    .byte_valid_o  (byte_valid_o),
    .frame_byte_o  (frame_byte_o),
    .last_byte_o   (last_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  // clamp into the margin bounds, then scale the joint range onto 0..255
  function automatic logic [7:0] joint_raw(int j, logic signed [15:0] ang);
    int a, top, bot, span, diff, q;
    a    = ang;
    top  = JNT_HI[j] - JNT_MARGIN[j];
    bot  = JNT_LO[j] + JNT_MARGIN[j];
    span = JNT_HI[j] - JNT_LO[j];
    if (a >= top) a = top;
    else if (a <= bot) a = bot;
    diff = a - JNT_LO[j];
    if (diff <= 0 || span <= 0) return 8'd0;
    q = (diff * 255) / span;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic void push_frame();
    logic [7:0] sum;
    sum = jacf_pkg::SUM_SEED;
    frame_due.push_back('{jacf_pkg::FRAME_START, 1'b0});
    frame_due.push_back('{jacf_pkg::FRAME_SET, 1'b0});
    frame_due.push_back('{jacf_pkg::FRAME_COUNT, 1'b0});
    for (int j = 0; j < 24; j++) begin
      sum += joint_target[j];
      frame_due.push_back('{joint_target[j], 1'b0});
    end
    frame_due.push_back('{8'(8'd0 - sum), 1'b0});
    frame_due.push_back('{jacf_pkg::FRAME_STOP, 1'b1});
  endfunction

  // drive one request beat, wait for it to be taken, update the prediction
  task automatic send_item(req_e rt, logic [4:0] ji, logic signed [15:0] ang);
    start_i       <= 1'b1;
    req_type_i    <= rt;
    joint_index_i <= ji;
    angle_i       <= ang;
    do @(posedge clk_i); while (busy_o);
    if (rt == REQ_SEND) push_frame();
    else if (ji < 24) joint_target[ji] = joint_raw(ji, ang);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && byte_valid_o) begin
      if (frame_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected frame beat: byte %h last %b", frame_byte_o, last_byte_o);
      end else begin
        frame_beat_t exp_beat;
        exp_beat = frame_due.pop_front();
        if (frame_byte_o !== exp_beat.frame_byte || last_byte_o !== exp_beat.last_byte) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("frame beat mismatch: expected byte %h last %b, got byte %h last %b",
                     exp_beat.frame_byte, exp_beat.last_byte, frame_byte_o, last_byte_o);
        end
      end
    end
  end

  task automatic test_default_frame();
    send_item(REQ_SEND, 5'd0, 16'sd0);
  endtask

  task automatic test_joint_extremes();
    send_item(REQ_SET, 5'd0, 16'sh7fff);
    send_item(REQ_SET, 5'd23, 16'sh8000);
    send_item(REQ_SET, 5'd11, 16'sh8000);   // lower bound above zero
    send_item(REQ_SET, 5'd8, 16'sh7fff);    // wide margin
    send_item(REQ_SET, 5'd10, 16'sd3213);   // exactly on upper clamp
    send_item(REQ_SET, 5'd12, -16'sd4643);  // exactly on lower clamp
    send_item(REQ_SET, 5'd13, 16'sd0);
    send_item(REQ_SET, 5'd4, 16'sd18230);
    send_item(REQ_SET, 5'd18, 16'sh8000);
    send_item(REQ_SEND, 5'd31, 16'shffff);
  endtask

  task automatic test_index_range();
    send_item(REQ_SET, 5'd24, 16'sh7fff);   // out of range, ignored
    send_item(REQ_SET, 5'd31, 16'sh8000);
    send_item(REQ_SET, 5'd23, 16'sd18226);
    send_item(REQ_SET, 5'd1, 16'sd1);
    send_item(REQ_SEND, 5'd24, 16'sh8000);  // fields of a send are don't care
  endtask

  task automatic test_random_commands(int n_items);
    int roll, j, a;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items - 40) idle_on = 1'b0;
      roll = $urandom_range(0, 99);
      j    = $urandom_range(0, 23);
      if (roll < 12) begin
        send_item(REQ_SEND, 5'($urandom), 16'($urandom));
      end else if (roll < 20) begin
        send_item(REQ_SET, 5'($urandom_range(24, 31)), 16'($urandom));
      end else if (roll < 45) begin
        send_item(REQ_SET, 5'(j), 16'($urandom));
      end else begin
        // near the joint range so the scaling sees most of its inputs
        a = JNT_LO[j] - 600 + $urandom_range(0, JNT_HI[j] - JNT_LO[j] + 1200);
        send_item(REQ_SET, 5'(j), 16'(a));
      end
    end
    send_item(REQ_SEND, 5'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    req_type_i    = 1'b0;
    joint_index_i = '0;
    angle_i       = '0;
    mismatch_cnt  = 0;
    idle_on       = 1'b1;
    for (int j = 0; j < 24; j++) joint_target[j] = joint_raw(j, 16'(JNT_DEFAULT[j]));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_frame();
    test_joint_extremes();
    test_index_range();
    test_random_commands(163);
    start_i <= 1'b0;
    for (int n = 0; n < 5000 && frame_due.size() > 0; n++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0 && frame_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/jacf_pkg.sv
rtl/jacf_ctrl.sv
rtl/jacf_datapath.sv
rtl/joint_angle_command_framer.sv
rtl/jacf_checker.sv
test/testbench.sv
